// ----- rtl/ip6f_pkg.sv -----
package ip6f_pkg;

    localparam int unsigned HDR_BYTES = 40;
    localparam int unsigned FRAG_BYTES = 8;
    localparam logic [3:0] IP_VERSION = 4'd6;

    localparam logic [7:0] NH_HOP      = 8'd0;
    localparam logic [7:0] NH_TCP      = 8'd6;
    localparam logic [7:0] NH_UDP      = 8'd17;
    localparam logic [7:0] NH_ROUTING  = 8'd43;
    localparam logic [7:0] NH_FRAGMENT = 8'd44;
    localparam logic [7:0] NH_ICMPV6   = 8'd58;
    localparam logic [7:0] NH_NONE     = 8'd59;
    localparam logic [7:0] NH_DSTOPT   = 8'd60;

    localparam logic [3:0] V_DELIVER   = 4'd0;
    localparam logic [3:0] V_DISABLED  = 4'd1;
    localparam logic [3:0] V_SHORT     = 4'd2;
    localparam logic [3:0] V_BAD_VER   = 4'd3;
    localparam logic [3:0] V_NOT_OURS  = 4'd4;
    localparam logic [3:0] V_FRAGMENT  = 4'd5;
    localparam logic [3:0] V_TCP       = 4'd6;
    localparam logic [3:0] V_UDP       = 4'd7;
    localparam logic [3:0] V_NO_NEXT   = 4'd8;
    localparam logic [3:0] V_UNKNOWN   = 4'd9;
    localparam logic [3:0] V_PAST_END  = 4'd10;

    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINK_IID     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GLOBAL_PFX   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GLOBAL_IID   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GLOBAL_VALID = 3'd4;

    localparam logic [63:0] LINK_LOCAL_PFX = 64'hfe80_0000_0000_0000;
    localparam logic [63:0] SOL_NODE_HI    = 64'hff02_0000_0000_0000;
    localparam logic [39:0] SOL_NODE_LO    = 40'h00_0000_01ff;
    localparam logic [7:0]  MCAST_BYTE     = 8'hff;
    localparam logic [7:0]  SCOPE_LINK     = 8'h02;
    localparam logic [7:0]  ALL_NODES_LO   = 8'h01;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  verdict;
        logic [15:0] upper_offset;
        logic [15:0] upper_length;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [31:0] accepted_count;
    } t_out_word;

    typedef struct packed {
        logic        enable;
        logic [63:0] link_local_iid;
        logic [63:0] global_prefix;
        logic [63:0] global_iid;
        logic        global_valid;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  version;
        logic [15:0] hdr_plen;
        logic [7:0]  nh_code;
        logic [16:0] nh_offset;
        logic [15:0] pkt_len;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
    } t_pkt_sum;

    function automatic logic is_ext(input logic [7:0] nh);
        return (nh == NH_HOP) || (nh == NH_ROUTING) || (nh == NH_DSTOPT);
    endfunction

endpackage

// ----- rtl/ip6f_parse.sv -----
module ip6f_parse #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  ip6f_pkg::t_in_word i_word,
    output ip6f_pkg::t_pkt_sum o_sum
);
    import ip6f_pkg::*;

    localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] PosHdr = POSITION_BITS'(HDR_BYTES);

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [63:0] r_shift, n_shift;
    logic [15:0] r_hpl, n_hpl;
    logic [7:0]  r_nh, n_nh;
    logic [63:0] r_src [2];
    logic [63:0] n_src [2];
    logic [63:0] r_dst [2];
    logic [63:0] n_dst [2];
    logic [16:0] r_off, n_off;
    logic        r_done, n_done;
    logic [3:0]  r_ver, n_ver;

    logic [POSITION_BITS-1:0] q;

    assign q = r_pos - PosHdr;

    always_comb begin
        n_pos   = r_pos;
        n_shift = r_shift;
        n_hpl   = r_hpl;
        n_nh    = r_nh;
        n_src   = r_src;
        n_dst   = r_dst;
        n_off   = r_off;
        n_done  = r_done;
        n_ver   = r_ver;
        if (r_pos != PosMax) begin
            n_pos = r_pos + 1'b1;
            if (r_pos < PosHdr) begin
                n_shift = {r_shift[55:0], i_word.pkt_byte};
                if (r_pos == POSITION_BITS'(7)) begin
                    n_ver = n_shift[63:60];
                    n_hpl = n_shift[31:16];
                    n_nh  = n_shift[15:8];
                end else if (r_pos == POSITION_BITS'(15)) begin
                    n_src[0] = n_shift;
                end else if (r_pos == POSITION_BITS'(23)) begin
                    n_src[1] = n_shift;
                end else if (r_pos == POSITION_BITS'(31)) begin
                    n_dst[0] = n_shift;
                end else if (r_pos == POSITION_BITS'(39)) begin
                    n_dst[1] = n_shift;
                end
            end else if (!r_done) begin
                if (!is_ext(r_nh)) begin
                    n_done = 1'b1;
                end else if (17'(q) == r_off) begin
                    n_shift = {56'd0, i_word.pkt_byte};
                end else if ((18'(q) == ({1'b0, r_off} + 18'd1)) &&
                             (16'(q) < r_hpl)) begin
                    n_nh  = r_shift[7:0];
                    n_off = r_off + 17'd8 + {6'd0, i_word.pkt_byte, 3'd0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_word.last_byte)) begin
            r_pos   <= '0;
            r_shift <= '0;
            r_hpl   <= '0;
            r_nh    <= '0;
            r_src   <= '{default: '0};
            r_dst   <= '{default: '0};
            r_off   <= '0;
            r_done  <= 1'b0;
            r_ver   <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_hpl   <= n_hpl;
            r_nh    <= n_nh;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_off   <= n_off;
            r_done  <= n_done;
            r_ver   <= n_ver;
        end
    end

    always_comb begin
        o_sum.version     = n_ver;
        o_sum.hdr_plen    = n_hpl;
        o_sum.nh_code     = n_nh;
        o_sum.nh_offset   = n_off;
        o_sum.pkt_len     = 16'(n_pos);
        o_sum.src_hi      = n_src[0];
        o_sum.src_lo      = n_src[1];
        o_sum.dst_hi      = n_dst[0];
        o_sum.dst_lo      = n_dst[1];
    end

endmodule

// ----- rtl/ip6f_dst_match.sv -----
module ip6f_dst_match (
    input  ip6f_pkg::t_cfg i_cfg,
    input  logic [63:0]    i_dst_hi,
    input  logic [63:0]    i_dst_lo,
    output logic           o_ours
);
    import ip6f_pkg::*;

    logic link_hit, global_hit, all_nodes_hit, sol_link_hit, sol_global_hit, sol_hi;

    assign sol_hi = (i_dst_hi == SOL_NODE_HI);
    assign link_hit = (i_dst_hi == LINK_LOCAL_PFX) && (i_dst_lo == i_cfg.link_local_iid);
    assign global_hit = i_cfg.global_valid && (i_dst_hi == i_cfg.global_prefix) &&
                        (i_dst_lo == i_cfg.global_iid);
    assign all_nodes_hit = (i_dst_hi[63:56] == MCAST_BYTE) &&
                           (i_dst_hi[55:48] == SCOPE_LINK) &&
                           (i_dst_lo[7:0] == ALL_NODES_LO);
    assign sol_link_hit = sol_hi &&
                          (i_dst_lo == {SOL_NODE_LO, i_cfg.link_local_iid[23:0]});
    assign sol_global_hit = i_cfg.global_valid && sol_hi &&
                            (i_dst_lo == {SOL_NODE_LO, i_cfg.global_iid[23:0]});

    assign o_ours = link_hit || global_hit || all_nodes_hit || sol_link_hit ||
                    sol_global_hit;

endmodule

// ----- rtl/ip6f_verdict.sv -----
module ip6f_verdict (
    input  ip6f_pkg::t_cfg     i_cfg,
    input  ip6f_pkg::t_pkt_sum i_sum,
    output logic [3:0]         o_verdict,
    output logic [15:0]        o_upper_offset,
    output logic [15:0]        o_upper_length,
    output logic               o_count
);
    import ip6f_pkg::*;

    logic        ours;
    logic [15:0] rx_payload;
    logic [15:0] plen;
    logic [16:0] off;

    ip6f_dst_match u_dst_match (
        .i_cfg    (i_cfg),
        .i_dst_hi (i_sum.dst_hi),
        .i_dst_lo (i_sum.dst_lo),
        .o_ours   (ours)
    );

    assign off = i_sum.nh_offset;
    assign rx_payload = i_sum.pkt_len - 16'(HDR_BYTES);
    assign plen = (i_sum.hdr_plen > rx_payload) ? rx_payload : i_sum.hdr_plen;

    always_comb begin
        o_verdict      = V_DELIVER;
        o_upper_offset = '0;
        o_upper_length = '0;
        o_count        = 1'b0;
        if (!i_cfg.enable) begin
            o_verdict = V_DISABLED;
        end else if (i_sum.pkt_len < 16'(HDR_BYTES)) begin
            o_verdict = V_SHORT;
        end else if (i_sum.version != IP_VERSION) begin
            o_verdict = V_BAD_VER;
        end else if (!ours) begin
            o_verdict = V_NOT_OURS;
        end else begin
            o_count = 1'b1;
            if ((off >= 17'(plen)) || is_ext(i_sum.nh_code)) begin
                o_verdict = V_PAST_END;
            end else begin
                case (i_sum.nh_code)
                    NH_FRAGMENT: begin
                        o_verdict = (18'(off) + 18'(FRAG_BYTES) > 18'(plen)) ?
                                    V_PAST_END : V_FRAGMENT;
                    end
                    NH_ICMPV6: begin
                        o_verdict      = V_DELIVER;
                        o_upper_offset = off[15:0];
                        o_upper_length = plen - off[15:0];
                    end
                    NH_TCP:  o_verdict = V_TCP;
                    NH_UDP:  o_verdict = V_UDP;
                    NH_NONE: o_verdict = V_NO_NEXT;
                    default: o_verdict = V_UNKNOWN;
                endcase
            end
        end
    end

endmodule

// ----- rtl/ipv6_receive_filter_parser.sv -----
// IPv6 receive filter and header parser.
// Input channel: one packet byte per word on i_in_word, last_byte set on the
// final byte; accepted when i_in_valid is high and o_in_stall is low.
// Output channel: one result word per packet, on o_out_word, taken when
// o_out_valid is high and i_out_stall is low. No result for other bytes.
// Config channel: i_cfg_index / i_cfg_data written when i_cfg_valid and
// o_cfg_ready are high; o_cfg_ready is always high. Write only while idle.
// A final byte is held in the input register; its result word is then
// loaded into the result register, built from the parser's next state.
// Throughput: one byte per clock while not stalled; parser updates per byte.
// A non-final byte is taken even while a result waits to be collected;
// a final byte waits in the input register until the result register frees.
// Stall on the output therefore backs up onto o_in_stall after one word.
// Reset (i_rst_n low, synchronous) clears the parser state, the accepted
// packet counter, the config registers and both valid flags.
// Byte count saturates at 2^POSITION_BITS - 1; further bytes are ignored.
module ipv6_receive_filter_parser #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  ip6f_pkg::t_in_word                    i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output ip6f_pkg::t_out_word                   o_out_word,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ip6f_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [63:0]                           i_cfg_data
);
    import ip6f_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    t_in_word   r_in_word;
    logic       r_out_valid;
    t_out_word  r_out_word;
    logic [31:0] r_count, n_count;

    logic       out_free;
    logic       fire;
    logic       in_take;
    t_pkt_sum   sum;
    logic [3:0] verdict;
    logic [15:0] upper_offset;
    logic [15:0] upper_length;
    logic       count_inc;
    logic       deliver;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_in_word.last_byte || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:       r_cfg.enable         <= i_cfg_data[0];
                REG_LINK_IID:     r_cfg.link_local_iid <= i_cfg_data;
                REG_GLOBAL_PFX:   r_cfg.global_prefix  <= i_cfg_data;
                REG_GLOBAL_IID:   r_cfg.global_iid     <= i_cfg_data;
                REG_GLOBAL_VALID: r_cfg.global_valid   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    ip6f_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in_word),
        .o_sum   (sum)
    );

    ip6f_verdict u_verdict (
        .i_cfg          (r_cfg),
        .i_sum          (sum),
        .o_verdict      (verdict),
        .o_upper_offset (upper_offset),
        .o_upper_length (upper_length),
        .o_count        (count_inc)
    );

    assign deliver = (verdict == V_DELIVER);
    assign n_count = r_count + {31'd0, count_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else if (fire && r_in_word.last_byte) begin
            r_out_valid <= 1'b1;
            r_count     <= n_count;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire && r_in_word.last_byte) begin
            r_out_word.verdict        <= verdict;
            r_out_word.upper_offset   <= upper_offset;
            r_out_word.upper_length   <= upper_length;
            r_out_word.source_high    <= deliver ? sum.src_hi : 64'd0;
            r_out_word.source_low     <= deliver ? sum.src_lo : 64'd0;
            r_out_word.accepted_count <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_word.last_byte) |=> r_out_valid)
        else $error("final byte gave no result word");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.verdict != V_DELIVER)) |->
        (r_out_word.upper_offset == 16'd0 && r_out_word.upper_length == 16'd0 &&
         r_out_word.source_high == 64'd0 && r_out_word.source_low == 64'd0))
        else $error("unused result fields not zero");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.verdict <= V_PAST_END))
        else $error("verdict code out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_word.last_byte && deliver) |=> (r_count == $past(r_count) + 32'd1))
        else $error("delivered packet not counted");

endmodule
